### rtl/ira_pkg.sv
`default_nettype none

package ira_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 8;
  localparam int DIGIT_W         = 5;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'd0;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 5'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT,
    ST_BAD
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic load_sign;
    logic load_digit;
    logic load_bad;
  } cmd_t;

  typedef struct packed {
    logic bad_radix;
    logic neg;
    logic digit_done;
    logic quot_zero;
    logic count_full;
    logic idx_zero;
    logic slot_free;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    if (d >= DIGIT_TEN) begin
      return CHAR_LETTER + CHAR_W'(d - DIGIT_TEN);
    end
    return CHAR_ZERO + CHAR_W'(d);
  endfunction

endpackage

`default_nettype wire

### rtl/ira_if.sv
`default_nettype none

interface ira_value_if #(parameter int WIDTH = ira_pkg::VALUE_WIDTH_DEF);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface ira_char_if;
  logic                         valid;
  logic                         ready;
  logic [ira_pkg::CHAR_W-1:0]   digit_char;
  logic                         last;
  logic                         bad_radix;
  modport source (output valid, output digit_char, output last, output bad_radix, input ready);
  modport sink (input valid, input digit_char, input last, input bad_radix, output ready);
endinterface

interface ira_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ira_pkg::RADIX_W-1:0] radix;
  modport source (output valid, output radix, input ready);
  modport sink (input valid, input radix, output ready);
endinterface

`default_nettype wire

### rtl/ira_ctrl.sv
`default_nettype none

module ira_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ira_pkg::status_t status,
  output ira_pkg::cmd_t         cmd
);

  ira_pkg::state_t state;
  ira_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ira_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ira_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (status.bad_radix) begin
            state_next = ira_pkg::ST_BAD;
          end else begin
            cmd.load   = 1'b1;
            state_next = ira_pkg::ST_DIVIDE;
          end
        end
      end
      ira_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.digit_done && (status.quot_zero || status.count_full)) begin
          state_next = status.neg ? ira_pkg::ST_SIGN : ira_pkg::ST_EMIT;
        end
      end
      ira_pkg::ST_SIGN: begin
        if (status.slot_free) begin
          cmd.load_sign = 1'b1;
          state_next    = ira_pkg::ST_EMIT;
        end
      end
      ira_pkg::ST_EMIT: begin
        if (status.slot_free) begin
          cmd.load_digit = 1'b1;
          if (status.idx_zero) begin
            state_next = ira_pkg::ST_IDLE;
          end
        end
      end
      ira_pkg::ST_BAD: begin
        if (status.slot_free) begin
          cmd.load_bad = 1'b1;
          state_next   = ira_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ira_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ira_datapath.sv
`default_nettype none

module ira_datapath #(
  parameter int VALUE_WIDTH = ira_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ira_pkg::cmd_t                cmd,
  output ira_pkg::status_t                  status,
  input  wire logic [VALUE_WIDTH-1:0]       value,
  input  wire logic                         cfg_write,
  input  wire logic [ira_pkg::RADIX_W-1:0]  cfg_radix,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [ira_pkg::CHAR_W-1:0]        digit_char,
  output logic                              last,
  output logic                              bad_radix
);

  localparam int IDX_W = $clog2(VALUE_WIDTH);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [ira_pkg::RADIX_W-1:0] radix;
  logic [VALUE_WIDTH-1:0]      quot;
  logic [ira_pkg::DIGIT_W-1:0] rem;
  logic [IDX_W-1:0]            bitcnt;
  logic [CNT_W-1:0]            count;
  logic [IDX_W-1:0]            idx;
  logic                        neg;
  logic [ira_pkg::DIGIT_W-1:0] store [VALUE_WIDTH];

  logic [ira_pkg::RADIX_W-1:0] trial;
  logic                        ge;
  logic [ira_pkg::DIGIT_W-1:0] rem_next;
  logic [VALUE_WIDTH-1:0]      quot_next;
  logic                        neg_in;
  logic [VALUE_WIDTH-1:0]      mag;

  // Restoring divide step: dividend bit in, quotient bit out.
  always_comb begin
    trial     = {rem, quot[VALUE_WIDTH-1]};
    ge        = (trial >= radix);
    rem_next  = ge ? ira_pkg::DIGIT_W'(trial - radix) : ira_pkg::DIGIT_W'(trial);
    quot_next = {quot[VALUE_WIDTH-2:0], ge};
    neg_in    = value[VALUE_WIDTH-1] && (radix == ira_pkg::RADIX_DEC);
    mag       = neg_in ? (~value + VALUE_WIDTH'(1)) : value;
  end

  always_comb begin
    status.bad_radix  = (radix < ira_pkg::RADIX_MIN) || (radix > ira_pkg::RADIX_MAX);
    status.neg        = neg;
    status.digit_done = (bitcnt == IDX_W'(VALUE_WIDTH - 1));
    status.quot_zero  = (quot_next == '0);
    status.count_full = (count == CNT_W'(VALUE_WIDTH - 1));
    status.idx_zero   = (idx == '0);
    status.slot_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= ira_pkg::RADIX_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        radix <= cfg_radix;
      end
      if (cmd.load_sign || cmd.load_digit || cmd.load_bad) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot   <= mag;
      rem    <= '0;
      bitcnt <= '0;
      count  <= '0;
      neg    <= neg_in;
    end else if (cmd.div_step) begin
      quot <= quot_next;
      if (status.digit_done) begin
        store[count[IDX_W-1:0]] <= rem_next;
        idx    <= count[IDX_W-1:0];
        count  <= count + CNT_W'(1);
        rem    <= '0;
        bitcnt <= '0;
      end else begin
        rem    <= rem_next;
        bitcnt <= bitcnt + IDX_W'(1);
      end
    end else if (cmd.load_digit) begin
      idx <= idx - IDX_W'(1);
    end

    if (cmd.load_sign) begin
      digit_char <= ira_pkg::CHAR_MINUS;
      last       <= 1'b0;
      bad_radix  <= 1'b0;
    end else if (cmd.load_digit) begin
      digit_char <= ira_pkg::digit_to_ascii(store[idx]);
      last       <= (idx == '0);
      bad_radix  <= 1'b0;
    end else if (cmd.load_bad) begin
      digit_char <= ira_pkg::CHAR_NONE;
      last       <= 1'b1;
      bad_radix  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/integer_to_radix_ascii_unit.sv
`default_nettype none

// Integer to ASCII converter in a configurable radix (2 to 32).
// number : one signed VALUE_WIDTH-bit integer per transfer.
// chars  : one ASCII character per transfer, most significant digit first;
//          last marks the final character. In radix 10 a negative value gives
//          a leading '-' and then its magnitude; other radices print the raw
//          two's complement pattern. A radix outside 2..32 gives one transfer
//          with digit_char 0, last 1 and bad_radix 1.
// cfg    : writes the radix; ready outside reset. Write only while idle, as
//          the radix is read on every division step.
// Operation: an item is loaded, then divided digit by digit, one quotient bit
// per cycle through a shared restoring divider; then the characters go out,
// one per cycle when chars is not stalled.
// One item is converted at a time; number is ready again once the last
// character sits in the output register, so the next item's division
// overlaps the wait for that character to be taken.
// Stall: a stalled chars holds the output register and the emit sequence.
// Reset: radix returns to 10, the output register empties, the controller
// returns to idle; number and cfg stay not ready while rst is held.
module integer_to_radix_ascii_unit #(
  parameter int VALUE_WIDTH = ira_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ira_value_if.sink number,
  ira_char_if.source chars,
  ira_cfg_if.sink   cfg
);

  ira_pkg::cmd_t    cmd;
  ira_pkg::status_t status;

  // Take configuration whenever reset is released; the divider reads the
  // radix on every step, so hold writes off until the block is idle.
  assign cfg.ready = !rst;

  ira_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .in_ready (number.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ira_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .value      (number.value[VALUE_WIDTH-1:0]),
    .cfg_write  (cfg.valid),
    .cfg_radix  (cfg.radix),
    .out_ready  (chars.ready),
    .out_valid  (chars.valid),
    .digit_char (chars.digit_char),
    .last       (chars.last),
    .bad_radix  (chars.bad_radix)
  );

endmodule

`default_nettype wire

### rtl/ira_checker.sv
`default_nettype none

module ira_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] digit_char,
  input wire logic       last,
  input wire logic       bad_radix
);

  // Hold a stalled character.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last))
    else $error("stalled character changed");

  // Drop input readiness while a number is being converted.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during conversion");

  // A flagged result is empty and closes the number.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_radix |-> last && (digit_char == 8'd0))
    else $error("malformed bad radix result");

  // A sign never ends a number.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_radix && (digit_char == 8'd45) |-> !last)
    else $error("sign marked as last");

endmodule

bind integer_to_radix_ascii_unit ira_checker u_ira_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (number.valid),
  .in_ready   (number.ready),
  .out_valid  (chars.valid),
  .out_ready  (chars.ready),
  .digit_char (chars.digit_char),
  .last       (chars.last),
  .bad_radix  (chars.bad_radix)
);

`default_nettype wire

### tb/ira_char_checker.sv
`default_nettype none

// Watches all three channels, predicts the character stream and compares.
module ira_char_checker (
  input  wire logic clk,
  input  wire logic rst,
  ira_value_if      number,
  ira_char_if       chars,
  ira_cfg_if        cfg,
  output int        fail_count,
  output int        chars_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import ira_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              bad_radix;
  } char_beat_t;

  char_beat_t         owed_beats[$];
  logic [RADIX_W-1:0] base_q = RADIX_RESET;
  int                 fails  = 0;
  int                 owed_n = 0;

  assign fail_count = fails;
  assign chars_owed = owed_n;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fails++;
  endtask

  // Queue the characters one number gives in the given base.
  function automatic void predict_digits(input logic [VW-1:0] v,
                                         input logic [RADIX_W-1:0] base);
    logic [VW-1:0]      mag;
    logic [DIGIT_W-1:0] digs [VW];
    logic [CHAR_W-1:0]  d8;
    char_beat_t         beat;
    logic               neg;
    int                 n;
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      beat = '{digit_char: CHAR_NONE, last: 1'b1, bad_radix: 1'b1};
      owed_beats.push_back(beat);
      return;
    end
    // only decimal is signed; the most negative value negates to itself,
    // which read unsigned is exactly its magnitude
    neg = v[VW-1] && (base == RADIX_DEC);
    mag = neg ? -v : v;
    n = 0;
    do begin
      digs[n] = DIGIT_W'(mag % VW'(base));
      mag     = mag / VW'(base);
      n++;
    end while (mag != '0 && n < VW);
    if (neg) begin
      beat = '{digit_char: CHAR_MINUS, last: 1'b0, bad_radix: 1'b0};
      owed_beats.push_back(beat);
    end
    for (int k = n - 1; k >= 0; k--) begin
      d8 = CHAR_W'(digs[k]);
      beat.digit_char = (digs[k] < DIGIT_TEN) ? CHAR_ZERO + d8
                                              : CHAR_LETTER - CHAR_W'(DIGIT_TEN) + d8;
      beat.last       = (k == 0);
      beat.bad_radix  = 1'b0;
      owed_beats.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    char_beat_t want;
    if (rst) begin
      owed_beats.delete();
      base_q = RADIX_RESET;
    end else begin
      if (chars.valid && chars.ready) begin
        if (owed_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h", chars.digit_char));
        end else begin
          want = owed_beats.pop_front();
          if (chars.digit_char !== want.digit_char) begin
            report_mismatch($sformatf("digit_char got 0x%02h, want 0x%02h",
                                      chars.digit_char, want.digit_char));
          end
          if (chars.last !== want.last) begin
            report_mismatch($sformatf("last got %b, want %b", chars.last, want.last));
          end
          if (chars.bad_radix !== want.bad_radix) begin
            report_mismatch($sformatf("bad_radix got %b, want %b",
                                      chars.bad_radix, want.bad_radix));
          end
        end
      end
      if (number.valid && number.ready) begin
        predict_digits(number.value, base_q);
      end
      if (cfg.valid && cfg.ready) begin
        base_q = cfg.radix;
      end
    end
    owed_n <= owed_beats.size();
  end

endmodule

`default_nettype wire

### tb/tb_integer_to_radix_ascii_unit.sv
`default_nettype none

// Stimulus and verdict for the integer to radix ASCII unit. The checker
// beside the block does all prediction and comparison.
module tb_integer_to_radix_ascii_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ira_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;

  logic clk        = 1'b0;
  logic rst;
  logic sink_ready = 1'b0;
  int   stall_left = 0;
  bit   idle_on    = 1'b0;
  int   mismatches;
  int   chars_owed;

  ira_value_if #(.WIDTH(VW)) number_ch ();
  ira_char_if                char_ch ();
  ira_cfg_if                 cfg_ch ();

  integer_to_radix_ascii_unit #(.VALUE_WIDTH(VW)) u_top (
    .clk    (clk),
    .rst    (rst),
    .number (number_ch),
    .chars  (char_ch),
    .cfg    (cfg_ch)
  );

  ira_char_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .number     (number_ch),
    .chars      (char_ch),
    .cfg        (cfg_ch),
    .fail_count (mismatches),
    .chars_owed (chars_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Character sink: stall at random times while idling is on,
  // otherwise take every transfer.
  assign char_ch.ready = sink_ready;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Offer one number and return at the edge of its transfer. Valid stays
  // high on return, so a following call without a gap keeps it high.
  task automatic send_number(input logic [VW-1:0] v);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      number_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    number_ch.valid <= 1'b1;
    number_ch.value <= v;
    do @(posedge clk); while (!number_ch.ready);
  endtask

  // Drop valid and hold off until every predicted character has gone by.
  // The negedge lets the checker book the final transfer first.
  task automatic settle_output();
    number_ch.valid <= 1'b0;
    @(negedge clk);
    wait (chars_owed == 0);
    @(posedge clk);
  endtask

  // Write the radix; only called with the block idle.
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix <= r;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Values biased towards digit-count boundaries, signs and extremes.
  function automatic logic [VW-1:0] pick_value(input logic [RADIX_W-1:0] base);
    logic [VW-1:0] v;
    logic [VW-1:0] p;
    case ($urandom_range(0, 7))
      0: v = VW'($urandom_range(0, 40));
      1: v = -VW'($urandom_range(1, 5000));
      2: v = VW'(1) << $urandom_range(0, VW - 1);
      3: v = (VW'(1) << $urandom_range(1, VW - 1)) - VW'(1);
      4: begin
        // a power of the base, wrapped to VW bits, or one below it
        p = VW'(1);
        repeat ($urandom_range(1, 8)) p = p * VW'(base);
        v = p - VW'($urandom_range(0, 1));
      end
      5: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(VW - 1){1'b0}}};
          1: v = {1'b0, {(VW - 1){1'b1}}};
          2: v = '1;
          default: v = '0;
        endcase
      end
      default: v = VW'($urandom);
    endcase
    return v;
  endfunction

  // Base used by each random phase; one invalid, one fully random.
  function automatic logic [RADIX_W-1:0] phase_base(input int p);
    case (p)
      0: return RADIX_DEC;
      1: return RADIX_MIN;
      2: return RADIX_W'(16);
      3: return RADIX_MAX;
      4: return RADIX_W'(3);
      5: return RADIX_W'(36);
      6: return RADIX_W'(8);
      7: return RADIX_W'($urandom_range(2, 32));
      8: return RADIX_W'($urandom_range(0, 63));
      default: return RADIX_DEC;
    endcase
  endfunction

  initial begin
    logic [RADIX_W-1:0] base;
    rst             <= 1'b1;
    number_ch.valid <= 1'b0;
    number_ch.value <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.radix    <= '0;
    repeat (9) @(posedge clk);
    rst     <= 1'b0;
    idle_on = 1'b1;

    // Decimal from reset: zero, unit steps, sign, both extremes, digit wrap
    send_number('0);
    send_number(VW'(1));
    send_number('1);
    send_number({1'b0, {(VW - 1){1'b1}}});
    send_number({1'b1, {(VW - 1){1'b0}}});
    send_number(VW'(9));
    send_number(VW'(10));
    send_number(-VW'(10));
    send_number(VW'(123456789));
    settle_output();

    // Binary: the longest strings, and the sign bit read as plain magnitude
    write_radix(RADIX_MIN);
    send_number('0);
    send_number('1);
    send_number({1'b1, {(VW - 1){1'b0}}});
    send_number(VW'(1));
    settle_output();

    // Hex and base 32 bring in the letters, up to the top digit
    write_radix(RADIX_W'(16));
    send_number(VW'(32'hDEAD_BEEF));
    send_number(-VW'(1));
    settle_output();
    write_radix(RADIX_MAX);
    send_number('1);
    send_number(VW'(31));
    settle_output();
    write_radix(RADIX_W'(3));
    send_number('1);
    settle_output();

    // Invalid radices: each gives one flagged empty transfer
    write_radix(RADIX_W'(0));
    send_number(VW'(5));
    settle_output();
    write_radix(RADIX_W'(1));
    send_number('1);
    settle_output();
    write_radix(RADIX_MAX + RADIX_W'(1));
    send_number(VW'(77));
    settle_output();
    write_radix('1);
    send_number('0);
    settle_output();

    // Random phases, one base each; the fifth and the last run with no idling at all
    for (int p = 0; p < 10; p++) begin
      base    = phase_base(p);
      idle_on = (p != 4) && (p != 9);
      write_radix(base);
      repeat ((p == 5) ? 10 : 30) send_number(pick_value(base));
      settle_output();
    end

    // Give any stray character time to show before the verdict
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/ira_pkg.sv
rtl/ira_if.sv
rtl/ira_ctrl.sv
rtl/ira_datapath.sv
rtl/integer_to_radix_ascii_unit.sv
rtl/ira_checker.sv
tb/ira_char_checker.sv
tb/tb_integer_to_radix_ascii_unit.sv
